>>> rtl/core/scfc_pkg.sv
// Shared constants and types for the serial command frame checker.
// Depends on nothing; imported by scfc_frame_track and the top level.
`timescale 1ns / 1ps

package scfc_pkg;

    localparam int MaxFrameBytes = 64;
    localparam int CountW        = $clog2(MaxFrameBytes + 1);
    localparam int HeadBytes     = 6;
    localparam int OutDataW      = 32;

    localparam logic [CountW-1:0] MaxCount = CountW'(MaxFrameBytes);
    localparam logic [CountW-1:0] MinCount = CountW'(4);
    localparam logic [CountW-1:0] SumStart = CountW'(2);

    localparam logic [7:0] HdrByte = 8'hFE;
    localparam logic [7:0] EndByte = 8'h16;
    localparam logic [7:0] LenByte = 8'h05;
    localparam logic [7:0] CodeLo  = 8'hA0;
    localparam logic [7:0] CodeHi  = 8'hBF;

    localparam logic KindByte = 1'b0;
    localparam logic KindIdle = 1'b1;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StFrameErr = 3'd1;
    localparam logic [2:0] StSumErr   = 3'd2;
    localparam logic [2:0] StLenErr   = 3'd3;
    localparam logic [2:0] StCodeErr  = 3'd4;

    typedef struct packed {
        logic        store_request;
        logic [15:0] param_value;
        logic [7:0]  func_code;
        logic [2:0]  status;
    } t_result;

    typedef struct packed {
        logic    has_result;
        t_result res;
    } t_track_out;

endpackage

>>> rtl/core/scfc_frame_track.sv
// Frame state (count, header bytes, running checksum) and the end-of-frame check.
// Depends on scfc_pkg.
`timescale 1ns / 1ps

module scfc_frame_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_kind,
    input  logic [7:0]           i_byte,
    output scfc_pkg::t_track_out o_eval
);
    import scfc_pkg::*;

    logic [CountW-1:0] r_count, n_count;
    logic              r_over, n_over;
    logic [7:0]        r_head [HeadBytes];
    logic [7:0]        n_head [HeadBytes];
    logic [7:0]        r_last0, n_last0, r_last1, n_last1;
    logic [7:0]        r_sum, n_sum;
    logic [7:0]        r_dsum0, n_dsum0, r_dsum1, n_dsum1;

    logic frame_err;
    logic [7:0] code;

    always_comb begin
        n_count = r_count;
        n_over  = r_over;
        n_head  = r_head;
        n_last0 = r_last0;
        n_last1 = r_last1;
        n_sum   = r_sum;
        n_dsum0 = r_dsum0;
        n_dsum1 = r_dsum1;
        if (i_step) begin
            if (i_kind == KindByte) begin
                if (r_count >= MaxCount) begin
                    n_over = 1'b1;
                end else begin
                    for (int i = 0; i < HeadBytes; i++) begin
                        if (r_count == CountW'(i)) begin
                            n_head[i] = i_byte;
                        end
                    end
                    n_dsum1 = r_dsum0;
                    n_dsum0 = r_sum;
                    if (r_count >= SumStart) begin
                        n_sum = r_sum + i_byte;
                    end
                    n_count = r_count + 1'b1;
                end
                n_last1 = r_last0;
                n_last0 = i_byte;
            end else begin
                // idle ends the frame: start the next one clean
                n_count = '0;
                n_over  = 1'b0;
                for (int i = 0; i < HeadBytes; i++) begin
                    n_head[i] = '0;
                end
                n_last0 = '0;
                n_last1 = '0;
                n_sum   = '0;
                n_dsum0 = '0;
                n_dsum1 = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_over  <= 1'b0;
            for (int i = 0; i < HeadBytes; i++) begin
                r_head[i] <= '0;
            end
            r_last0 <= '0;
            r_last1 <= '0;
            r_sum   <= '0;
            r_dsum0 <= '0;
            r_dsum1 <= '0;
        end else begin
            r_count <= n_count;
            r_over  <= n_over;
            r_head  <= n_head;
            r_last0 <= n_last0;
            r_last1 <= n_last1;
            r_sum   <= n_sum;
            r_dsum0 <= n_dsum0;
            r_dsum1 <= n_dsum1;
        end
    end

    assign frame_err = r_over || (r_count < MinCount) || (r_head[0] != HdrByte) ||
                       (r_head[1] != HdrByte) || (r_last0 != EndByte);
    assign code = r_head[3];

    always_comb begin
        o_eval.has_result        = (r_count != '0) || r_over;
        o_eval.res.status        = StOk;
        o_eval.res.func_code     = '0;
        o_eval.res.param_value   = '0;
        o_eval.res.store_request = 1'b0;
        if (frame_err) begin
            o_eval.res.status = StFrameErr;
        end else begin
            o_eval.res.func_code   = code;
            o_eval.res.param_value = {r_head[4], r_head[5]};
            if (r_dsum1 != r_last1) begin
                o_eval.res.status = StSumErr;
            end else if (r_head[2] != LenByte) begin
                o_eval.res.status = StLenErr;
            end else if ((code < CodeLo) || (code > CodeHi)) begin
                o_eval.res.status = StCodeErr;
            end else begin
                o_eval.res.store_request = ((code & CodeLo) == CodeLo);
            end
        end
    end

endmodule

>>> rtl/core/serial_command_frame_checker.sv
// Serial command frame checker: top level with input and result registers.
// Depends on scfc_pkg and scfc_frame_track.
//
// Usage: the slave stream carries one request per received UART byte
// (tuser = 0, byte in tdata) or per line-idle event (tuser = 1). An idle
// closes the current frame; if the frame held any byte, one result leaves on
// the master stream with status, function code, parameter value and the
// store flag. An idle with no bytes since the previous idle gives nothing.
// Every request is taken into an input register, then the frame state is
// updated (or checked and cleared) as it leaves, and a result goes into the
// result register on the master side. One request is taken per cycle while
// tready is high; the rate is set by the single input stage feeding the
// result register. When the receiver stalls, the result register holds; data
// bytes still flow, and only an idle that finds the result register full
// waits in the input register, dropping tready until the result is taken.
// Reset (synchronous, active low) empties both registers and clears the
// frame state; no clearing pass is needed.
`timescale 1ns / 1ps

module serial_command_frame_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
    input  logic                           s_axis_tuser,   // [0] kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [scfc_pkg::OutDataW-1:0]  m_axis_tdata    // [2:0] status, [10:3] func_code,
                                           // [26:11] param_value, [27] store_request
);
    import scfc_pkg::*;

    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;
    logic       r_out_valid, n_out_valid;
    t_result    r_out_res, n_out_res;

    logic       stage_go;
    t_track_out eval;

    // a byte never waits; an idle waits only for room in the result register
    assign stage_go = r_in_valid &&
                      ((r_in_kind == KindByte) || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || stage_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    scfc_frame_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (stage_go),
        .i_kind  (r_in_kind),
        .i_byte  (r_in_byte),
        .o_eval  (eval)
    );

    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_res   = r_out_res;
        if (stage_go && (r_in_kind == KindIdle) && eval.has_result) begin
            n_out_valid = 1'b1;
            n_out_res   = eval.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res <= n_out_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_res.store_request, r_out_res.param_value,
                            r_out_res.func_code, r_out_res.status};

    a_store_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_res.store_request) |-> (r_out_res.status == StOk))
        else $error("store flag set on a failed frame");

    a_frame_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out_res.status == StFrameErr)) |->
        ((r_out_res.func_code == '0) && (r_out_res.param_value == '0)))
        else $error("frame error result carries code or value");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && (r_in_kind == KindIdle) && r_out_valid &&
                            !m_axis_tready))
        else $error("input stalled without a blocked idle");

    a_result_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid && !(stage_go && (r_in_kind == KindIdle))) |=>
        !m_axis_tvalid)
        else $error("result appeared without an idle");

endmodule
